[hw/rtl/cewcs_pkg.sv]
// Shared types and codes for the crash-emulating write cache store.
// No dependencies.
package cewcs_pkg;

   localparam logic [3:0] CMD_READ    = 4'd0;
   localparam logic [3:0] CMD_WRITE   = 4'd1;
   localparam logic [3:0] CMD_ZERO    = 4'd2;
   localparam logic [3:0] CMD_DISCARD = 4'd3;
   localparam logic [3:0] CMD_FLUSH   = 4'd4;
   localparam logic [3:0] CMD_FLUSH_B = 4'd5;
   localparam logic [3:0] CMD_CRASH   = 4'd6;
   localparam logic [3:0] CMD_SET_ERR = 4'd7;
   localparam logic [3:0] CMD_RECOVER = 4'd8;
   localparam logic [3:0] CMD_GET     = 4'd9;

   localparam logic [2:0] MODE_NORMAL  = 3'd0;
   localparam logic [2:0] MODE_RD_ERR  = 3'd1;
   localparam logic [2:0] MODE_WR_ERR  = 3'd2;
   localparam logic [2:0] MODE_RW_ERR  = 3'd3;
   localparam logic [2:0] MODE_CRASHED = 3'd4;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_IOERR = 2'd1;
   localparam logic [1:0] ST_BAD   = 2'd2;

   typedef logic [3:0] cmd_type;

endpackage

[hw/rtl/crash_emulating_write_cache_store.sv]
// Top level of the crash-emulating write cache store.
// Uses cewcs_pkg and two cewcs_mem word memories (cache and persistent layer).
//
// One word at a time: ready is low while a command runs and until its result
// word is taken. Discard, crash, the mode commands and a flush of an uncached
// block answer straight from decode; a write or zero-word to a cached block
// writes the cache word, and a read takes the word from the cache or else the
// persistent layer. A write to a block missing from the cache first copies it
// up from the persistent layer, word by word (read, then write); if the block
// is missing from the persistent layer too, it is first zeroed one word per
// cycle. A block flush walks the block, copying it down, and flush all visits
// every block and copies down each cached one. No clearing pass: valid bits
// reset at once.
module crash_emulating_write_cache_store #(
   parameter int NUM_BLOCKS      = 1024,
   parameter int WORDS_PER_BLOCK = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_cmd,
   input  logic [9:0]  req_block_index,
   input  logic [8:0]  req_word_index,
   input  logic [63:0] req_data_word,
   input  logic [1:0]  req_error_mode,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_read_data,
   output logic [1:0]  rsp_status,
   output logic [2:0]  rsp_mode_now
);
   localparam int BW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int WW = (WORDS_PER_BLOCK > 1) ? $clog2(WORDS_PER_BLOCK) : 1;
   localparam int AW = BW + WW;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DEC   = 4'd1;
   localparam logic [3:0] S_ZERO  = 4'd2;  // zero persistent block
   localparam logic [3:0] S_CPRD  = 4'd3;  // read source word
   localparam logic [3:0] S_CPWR  = 4'd4;  // write destination word
   localparam logic [3:0] S_WORD  = 4'd5;  // final word write
   localparam logic [3:0] S_RD    = 4'd6;
   localparam logic [3:0] S_RDW   = 4'd7;
   localparam logic [3:0] S_SCAN  = 4'd8;  // flush-all block scan
   localparam logic [3:0] S_RESP  = 4'd9;

   logic [3:0]  state_ff, state_in;
   cewcs_pkg::cmd_type cmd_ff;
   logic [BW-1:0] blk_ff, blk_in;
   logic [WW-1:0] wrd_ff;
   logic [WW-1:0] cnt_ff, cnt_in;
   logic        addr_ok_ff, blk_ok_ff;
   logic [63:0] data_ff;
   logic [1:0]  emode_ff;
   logic        down_ff, down_in;   // copy direction: 1 = cache to persistent
   logic        scan_ff, scan_in;   // flush walk belongs to flush all
   logic [NUM_BLOCKS-1:0] cv_ff, pv_ff;
   logic [NUM_BLOCKS-1:0] cv_in, pv_in;
   logic [2:0]  mode_ff, mode_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rdata_ff, rdata_in;
   logic [1:0]  status_ff, status_in;

   logic          c_we, p_we;
   logic [AW-1:0] c_addr, p_addr;
   logic [63:0]   c_wd, p_wd, c_rd, p_rd;
   logic          rd_ref, wr_ref;

   cewcs_mem #(.ADDR_W(AW)) u_cache (
      .clock(clock), .wr_en(c_we), .addr(c_addr), .wr_data(c_wd), .rd_data(c_rd));
   cewcs_mem #(.ADDR_W(AW)) u_persist (
      .clock(clock), .wr_en(p_we), .addr(p_addr), .wr_data(p_wd), .rd_data(p_rd));

   assign rd_ref = (mode_ff == cewcs_pkg::MODE_RD_ERR) || (mode_ff == cewcs_pkg::MODE_RW_ERR)
                   || (mode_ff == cewcs_pkg::MODE_CRASHED);
   assign wr_ref = (mode_ff == cewcs_pkg::MODE_WR_ERR) || (mode_ff == cewcs_pkg::MODE_RW_ERR)
                   || (mode_ff == cewcs_pkg::MODE_CRASHED);

   assign req_ready     = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rdata_ff;
   assign rsp_status    = status_ff;
   assign rsp_mode_now  = mode_ff;

   // capture request
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cmd_ff     <= req_cmd;
         wrd_ff     <= req_word_index[WW-1:0];
         data_ff    <= req_data_word;
         emode_ff   <= req_error_mode;
         blk_ok_ff  <= 32'(req_block_index) < NUM_BLOCKS;
         addr_ok_ff <= (32'(req_block_index) < NUM_BLOCKS)
                       && (32'(req_word_index) < WORDS_PER_BLOCK);
      end
   end

   always_comb begin
      state_in     = state_ff;
      blk_in       = blk_ff;
      cnt_in       = cnt_ff;
      down_in      = down_ff;
      scan_in      = scan_ff;
      cv_in        = cv_ff;
      pv_in        = pv_ff;
      mode_in      = mode_ff;
      rsp_valid_in = rsp_valid_ff;
      rdata_in     = rdata_ff;
      status_in    = status_ff;
      c_we = 1'b0;
      p_we = 1'b0;
      c_addr = {blk_ff, wrd_ff};
      p_addr = {blk_ff, wrd_ff};
      c_wd = data_ff;
      p_wd = 64'd0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               blk_in   = req_block_index[BW-1:0];
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            rdata_in  = 64'd0;
            status_in = cewcs_pkg::ST_OK;
            cnt_in    = '0;
            scan_in   = 1'b0;
            state_in  = S_RESP;
            unique case (cmd_ff)
               cewcs_pkg::CMD_READ: begin
                  if (rd_ref) status_in = cewcs_pkg::ST_IOERR;
                  else if (addr_ok_ff) state_in = S_RD;
               end
               cewcs_pkg::CMD_WRITE, cewcs_pkg::CMD_ZERO: begin
                  if (wr_ref) status_in = cewcs_pkg::ST_IOERR;
                  else if (addr_ok_ff) begin
                     if (!pv_ff[blk_ff]) state_in = S_ZERO;
                     else if (!cv_ff[blk_ff]) begin
                        down_in = 1'b0; state_in = S_CPRD;
                     end else state_in = S_WORD;
                  end
               end
               cewcs_pkg::CMD_DISCARD: begin
                  if (wr_ref) status_in = cewcs_pkg::ST_IOERR;
                  else if (blk_ok_ff) begin
                     cv_in[blk_ff] = 1'b0; pv_in[blk_ff] = 1'b0;
                  end
               end
               cewcs_pkg::CMD_FLUSH: begin
                  if (wr_ref) status_in = cewcs_pkg::ST_IOERR;
                  else begin
                     blk_in = '0; scan_in = 1'b1; state_in = S_SCAN;
                  end
               end
               cewcs_pkg::CMD_FLUSH_B: begin
                  if (wr_ref) status_in = cewcs_pkg::ST_IOERR;
                  else if (blk_ok_ff && cv_ff[blk_ff]) begin
                     down_in = 1'b1; state_in = S_CPRD;
                  end
               end
               cewcs_pkg::CMD_CRASH: begin
                  if (mode_ff == cewcs_pkg::MODE_CRASHED) status_in = cewcs_pkg::ST_BAD;
                  else begin
                     cv_in = '0; mode_in = cewcs_pkg::MODE_CRASHED;
                  end
               end
               cewcs_pkg::CMD_SET_ERR: begin
                  if (mode_ff == cewcs_pkg::MODE_CRASHED || emode_ff == 2'd0)
                     status_in = cewcs_pkg::ST_BAD;
                  else mode_in = {1'b0, emode_ff};
               end
               cewcs_pkg::CMD_RECOVER: begin
                  if (mode_ff == cewcs_pkg::MODE_NORMAL) status_in = cewcs_pkg::ST_BAD;
                  else mode_in = cewcs_pkg::MODE_NORMAL;
               end
               default: ;
            endcase
         end
         S_ZERO: begin
            p_we = 1'b1;
            p_addr = {blk_ff, cnt_ff};
            p_wd = 64'd0;
            if (32'(cnt_ff) == WORDS_PER_BLOCK - 1) begin
               cnt_in = '0;
               pv_in[blk_ff] = 1'b1;
               // fresh block: cache copy is zeros too
               if (!cv_ff[blk_ff]) begin
                  down_in = 1'b0; state_in = S_CPRD;
               end else state_in = S_WORD;
            end else cnt_in = cnt_ff + 1'b1;
         end
         S_CPRD: begin
            c_addr = {blk_ff, cnt_ff};
            p_addr = {blk_ff, cnt_ff};
            state_in = S_CPWR;
         end
         S_CPWR: begin
            c_addr = {blk_ff, cnt_ff};
            p_addr = {blk_ff, cnt_ff};
            if (down_ff) begin
               p_we = 1'b1; p_wd = c_rd;
            end else begin
               c_we = 1'b1; c_wd = p_rd;
            end
            if (32'(cnt_ff) == WORDS_PER_BLOCK - 1) begin
               cnt_in = '0;
               if (down_ff) begin
                  pv_in[blk_ff] = 1'b1;
                  cv_in[blk_ff] = 1'b0;
                  if (scan_ff) begin
                     if (32'(blk_ff) == NUM_BLOCKS - 1) state_in = S_RESP;
                     else begin
                        blk_in = blk_ff + 1'b1; state_in = S_SCAN;
                     end
                  end else state_in = S_RESP;
               end else begin
                  cv_in[blk_ff] = 1'b1;
                  state_in = S_WORD;
               end
            end else begin
               cnt_in = cnt_ff + 1'b1;
               state_in = S_CPRD;
            end
         end
         S_WORD: begin
            c_we = 1'b1;
            c_wd = (cmd_ff == cewcs_pkg::CMD_WRITE) ? data_ff : 64'd0;
            state_in = S_RESP;
         end
         S_RD: state_in = S_RDW;
         S_RDW: begin
            if (cv_ff[blk_ff]) rdata_in = c_rd;
            else if (pv_ff[blk_ff]) rdata_in = p_rd;
            state_in = S_RESP;
         end
         S_SCAN: begin
            if (cv_ff[blk_ff]) begin
               cnt_in = '0; down_in = 1'b1; state_in = S_CPRD;
            end else if (32'(blk_ff) == NUM_BLOCKS - 1) state_in = S_RESP;
            else blk_in = blk_ff + 1'b1;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cv_ff        <= '0;
         pv_ff        <= '0;
         mode_ff      <= cewcs_pkg::MODE_NORMAL;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cv_ff        <= cv_in;
         pv_ff        <= pv_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      blk_ff    <= blk_in;
      cnt_ff    <= cnt_in;
      down_ff   <= down_in;
      scan_ff   <= scan_in;
      rdata_ff  <= rdata_in;
      status_ff <= status_in;
   end
endmodule

[hw/rtl/cewcs_mem.sv]
// Single-port word memory with registered read data.
// No dependencies.
module cewcs_mem #(
   parameter int ADDR_W = 19
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] addr,
   input  logic [63:0]       wr_data,
   output logic [63:0]       rd_data
);
   logic [63:0] mem [2**ADDR_W];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

[hw/rtl/cewcs_checker.sv]
// Port-level checks for crash_emulating_write_cache_store.
// Uses cewcs_pkg; bound to the top level below.
module cewcs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_read_data,
   input logic [1:0]  rsp_status,
   input logic [2:0]  rsp_mode_now
);
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data))
      else $error("result word changed while stalled");
   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("accepted a second word while busy");
   a_status_rng: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 2'd3 && rsp_mode_now <= cewcs_pkg::MODE_CRASHED)
      else $error("status or mode out of range");
   a_no_data_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != cewcs_pkg::ST_OK |-> rsp_read_data == 64'd0)
      else $error("refused word carries data");
endmodule

bind crash_emulating_write_cache_store cewcs_checker u_cewcs_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_read_data(rsp_read_data), .rsp_status(rsp_status),
   .rsp_mode_now(rsp_mode_now));
